@@ rtl/assert_macros.svh @@
// Assertion macros for the core RTL file.
// No dependencies; assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MTF_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtf assertion failed");
`define MTF_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
    else $error("mtf assertion failed");
`else
`define MTF_ASSERT(name, clk, rst_n, prop)
`define MTF_ASSERT_NR(name, clk, prop)
`endif

`endif

@@ rtl/mtf_pkg.sv @@
// Package for the move-to-front rank core: sizes, types and helper functions.
// No dependencies.
package mtf_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int ITEM_W    = 9;                       // item_id / item_count width
    localparam int RANK_W    = 8;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = (CNT_W > ITEM_W) ? CNT_W : ITEM_W;

    localparam logic CMD_ACCESS  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic              rebuild;
        logic              shift;
        logic [VAL_W-1:0]  id;
        logic [IDX_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
    } t_cell_ctl;

    // register value -> active item count, clamped to 1..MAX_ITEMS
    function automatic logic [CNT_W-1:0] eff_count(input logic [ITEM_W-1:0] v);
        logic [VAL_W-1:0] e;
        e = VAL_W'(v);
        if (e == '0)
            e = VAL_W'(1);
        else if (e > VAL_W'(MAX_ITEMS))
            e = VAL_W'(MAX_ITEMS);
        return CNT_W'(e);
    endfunction

    // initial contents of one list slot
    function automatic logic [VAL_W-1:0] cell_init(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] count);
        logic [VAL_W-1:0] r;
        if (VAL_W'(idx) < VAL_W'(count))
            r = VAL_W'(idx) + VAL_W'(1);
        else
            r = '0;
        return r;
    endfunction

    function automatic logic [RANK_W-1:0] sat_rank(input logic [IDX_W-1:0] pos);
        logic [IDX_W+RANK_W-1:0] w;
        w = (IDX_W+RANK_W)'(pos);
        if (w > (IDX_W+RANK_W)'(255))
            w = (IDX_W+RANK_W)'(255);
        return w[RANK_W-1:0];
    endfunction

    localparam logic [CNT_W-1:0] RESET_COUNT = eff_count(ITEM_W'(256));

endpackage

@@ rtl/mtf_if.sv @@
// Handshake channel interfaces of the move-to-front rank core.
// Depends on mtf_pkg.
interface mtf_in_if;
    import mtf_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [ITEM_W-1:0] item_id;
    modport source (output valid, command, item_id, input ready);
    modport sink   (input valid, command, item_id, output ready);
endinterface

interface mtf_out_if;
    import mtf_pkg::*;
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic              bad_item;
    modport source (output valid, rank, bad_item, input ready);
    modport sink   (input valid, rank, bad_item, output ready);
endinterface

interface mtf_cfg_if;
    import mtf_pkg::*;
    logic              valid;
    logic              ready;
    logic [ITEM_W-1:0] item_count;
    modport source (output valid, item_count, input ready);
    modport sink   (input valid, item_count, output ready);
endinterface

@@ rtl/move_to_front_rank_core.sv @@
// Move-to-front rank core: a row of MAX_ITEMS list slots with an encoder.
// An access result passes ST_SHIFT and then the output register; a restart item gives no result.
// Accesses do not overlap: compare+encode, then shift of the row, held while the output stalls.
// Reset (sync, active low): list holds 1..256 top down, item count 256.
// A config write rebuilds the list at the same clock edge.
`include "assert_macros.svh"

module move_to_front_rank_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtf_in_if.sink    i_in,
    mtf_out_if.source o_out,
    mtf_cfg_if.sink   i_cfg
);
    import mtf_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_active;
    logic [VAL_W-1:0]  r_id;
    logic              r_bad;
    logic [IDX_W-1:0]  r_pos;
    logic              r_found;
    logic              r_out_valid;
    logic [RANK_W-1:0] r_rank;
    logic              r_out_bad;

    t_cell_ctl         ctl;
    logic              in_ready;
    logic              out_load;
    logic              in_fire;
    logic              cfg_fire;
    logic              bad_in;
    logic [VAL_W-1:0]  id_ext;

    logic [VAL_W-1:0]     cell_val [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] match;
    logic [IDX_W-1:0]     enc_pos;
    logic                 enc_found;

    // nothing is taken while reset is held
    assign i_cfg.ready = i_rst_n;
    assign cfg_fire    = i_cfg.valid && i_rst_n;
    assign i_in.ready  = in_ready && i_rst_n;
    assign in_fire     = i_in.valid && in_ready && i_rst_n;
    assign id_ext      = VAL_W'(i_in.item_id);
    assign bad_in      = (id_ext == '0) || (id_ext > VAL_W'(r_active));

    always_comb begin
        n_state     = r_state;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        ctl.rebuild = 1'b0;
        ctl.shift   = 1'b0;
        ctl.id      = r_id;
        ctl.pos     = r_pos;
        ctl.count   = r_active;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                ctl.id   = id_ext;
                if (i_in.valid && (i_in.command == CMD_RESTART))
                    ctl.rebuild = 1'b1;
                else if (i_in.valid)
                    n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load  = 1'b1;
                    ctl.shift = !r_bad;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (cfg_fire) begin
            ctl.rebuild = 1'b1;
            ctl.count   = eff_count(i_cfg.item_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= RESET_COUNT;
        end else begin
            r_state <= n_state;
            if (cfg_fire)
                r_active <= eff_count(i_cfg.item_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in.command == CMD_ACCESS)) begin
            r_id    <= id_ext;
            r_bad   <= bad_in;
            r_pos   <= enc_pos;
            r_found <= enc_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_rank    <= r_bad ? '0 : sat_rank(r_pos);
            r_out_bad <= r_bad;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.rank     = r_rank;
    assign o_out.bad_item = r_out_bad;

    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        logic [VAL_W-1:0] prev;
        if (k == 0) begin : g_top
            assign prev = ctl.id;
        end else begin : g_rest
            assign prev = cell_val[k-1];
        end
        mtf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(k)),
            .i_ctl   (ctl),
            .i_prev  (prev),
            .o_val   (cell_val[k]),
            .o_match (match[k])
        );
    end

    mtf_enc u_enc (
        .i_match (match),
        .o_pos   (enc_pos),
        .o_found (enc_found)
    );

    // list entries are distinct apart from empty slots
    `MTF_ASSERT(a_match_unique, i_clk, i_rst_n, (r_state == ST_IDLE && id_ext != '0) |-> $onehot0(match))
    // a valid item is always somewhere in the list
    `MTF_ASSERT(a_found, i_clk, i_rst_n, (r_state == ST_SHIFT && !r_bad) |-> r_found)
    `MTF_ASSERT(a_access_shift, i_clk, i_rst_n, (in_fire && i_in.command == CMD_ACCESS && !cfg_fire) |=> (r_state == ST_SHIFT))

endmodule

@@ rtl/mtf_cell.sv @@
// One slot of the ordered list: holds an item, compares it, shifts from above.
// Depends on mtf_pkg.
module mtf_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [mtf_pkg::IDX_W-1:0] i_index,
    input  mtf_pkg::t_cell_ctl       i_ctl,
    input  logic [mtf_pkg::VAL_W-1:0] i_prev,
    output logic [mtf_pkg::VAL_W-1:0] o_val,
    output logic                     o_match
);
    import mtf_pkg::*;

    logic [VAL_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= cell_init(i_index, RESET_COUNT);
        end else if (i_ctl.rebuild) begin
            r_val <= cell_init(i_index, i_ctl.count);
        end else if (i_ctl.shift && (i_index <= i_ctl.pos)) begin
            // slot 0 sees the accessed item on i_prev
            r_val <= i_prev;
        end
    end

    assign o_val   = r_val;
    assign o_match = (r_val == i_ctl.id);

endmodule

@@ rtl/mtf_enc.sv @@
// One-hot to binary encoder for the slot match vector.
// Depends on mtf_pkg.
module mtf_enc (
    input  logic [mtf_pkg::MAX_ITEMS-1:0] i_match,
    output logic [mtf_pkg::IDX_W-1:0]     o_pos,
    output logic                          o_found
);
    import mtf_pkg::*;

    always_comb begin
        o_pos = '0;
        for (int k = 0; k < MAX_ITEMS; k++) begin
            if (i_match[k])
                o_pos = o_pos | IDX_W'(k);
        end
    end

    assign o_found = |i_match;

endmodule

@@ test/tb.sv @@
// Testbench for move_to_front_rank_core: directed table, then random phases over item counts.
// A local copy of the list predicts rank and bad_item for each accepted access without a table expectation.
// Depends on mtf_pkg, the channel interfaces in mtf_if.sv and the core RTL.
module tb;
    import mtf_pkg::*;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              bad;
    } t_rank_res;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              cmd;
        logic [ITEM_W-1:0] value;  // item_id, or item_count on a config row
        logic              typed;  // 1: use the expectation below
        t_rank_res         want;
    } t_dir_row;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_BURSTY
    } t_ready_mode;

    localparam int DIR_ROWS    = 26;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 92;
    localparam int IDLE_LIMIT  = 1000;
    localparam int SETTLE      = 4;

    logic i_clk;
    logic i_rst_n;

    mtf_in_if  in_ch ();
    mtf_out_if out_ch ();
    mtf_cfg_if cfg_ch ();

    move_to_front_rank_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    logic [ITEM_W-1:0] order_model [MAX_ITEMS];
    int                live_count;
    t_rank_res         pending_ranks [$];
    int                err_cnt;
    int                burst_left;
    bit                no_gaps;
    t_ready_mode       ready_mode;
    int                stall_left;
    int                quiet_cycles;

    t_dir_row          dir_tab [DIR_ROWS];
    logic [ITEM_W-1:0] phase_cnt [PHASES];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- list predictor ----------------
    function automatic void rebuild_order();
        for (int k = 0; k < MAX_ITEMS; k++)
            order_model[k] = (k < live_count) ? ITEM_W'(k + 1) : '0;
    endfunction

    function automatic void set_count(input logic [ITEM_W-1:0] v);
        live_count = int'(v);
        if (live_count < 1)
            live_count = 1;
        if (live_count > MAX_ITEMS)
            live_count = MAX_ITEMS;
        rebuild_order();
    endfunction

    function automatic bit mtf_access(input logic cmd, input logic [ITEM_W-1:0] id,
                                      output t_rank_res res);
        int pos;
        res = '0;
        if (cmd == CMD_RESTART) begin
            rebuild_order();
            return 1'b0;
        end
        if (id == '0 || int'(id) > live_count) begin
            res.bad = 1'b1;
            return 1'b1;
        end
        pos = 0;
        while (pos < live_count && order_model[pos] != id)
            pos++;
        for (int k = pos; k > 0; k--)
            order_model[k] = order_model[k-1];
        order_model[0] = id;
        res.rank = (pos > 255) ? RANK_W'(255) : RANK_W'(pos);
        return 1'b1;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_item(input logic cmd, input logic [ITEM_W-1:0] id,
                             input logic typed, input t_rank_res want);
        t_rank_res res;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!no_gaps) begin
                gap = $urandom_range(1, 6);
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.item_id <= id;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (mtf_access(cmd, id, res))
            pending_ranks = {pending_ranks, (typed ? want : res)};
    endtask

    // drop valid, let every result come back, then give a restart time to finish
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_ranks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [ITEM_W-1:0] v);
        drain_results();
        @(negedge i_clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.item_count <= v;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        set_count(v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ---------------- receiver stall pattern ----------------
    always @(negedge i_clk) begin
        case (ready_mode)
            RDY_ALWAYS: begin
                out_ch.ready <= 1'b1;
            end
            RDY_RANDOM: begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 12);
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_rank_res want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_ranks.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected item rank=%0d bad_item=%0b",
                         $time, out_ch.rank, out_ch.bad_item);
            end else begin
                want = pending_ranks.pop_front();
                if (out_ch.rank !== want.rank) begin
                    err_cnt++;
                    $display("%0t: rank expected %0d actual %0d",
                             $time, want.rank, out_ch.rank);
                end
                if (out_ch.bad_item !== want.bad) begin
                    err_cnt++;
                    $display("%0t: bad_item expected %0b actual %0b",
                             $time, want.bad, out_ch.bad_item);
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        int                eff;
        int                r;
        logic              cmd;
        logic [ITEM_W-1:0] id;

        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_ACCESS;
        in_ch.item_id     = '0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.item_count = '0;
        i_rst_n           = 1'b0;
        err_cnt           = 0;
        burst_left        = 0;
        no_gaps           = 1'b0;
        ready_mode        = RDY_ALWAYS;
        stall_left        = 0;
        quiet_cycles      = 0;
        set_count(ITEM_W'(256));

        dir_tab = '{
            '{ROW_ITEM, CMD_ACCESS,  9'd1,   1'b1, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd256, 1'b1, '{8'd255, 1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd256, 1'b1, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd0,   1'b1, '{8'd0,   1'b1}},
            '{ROW_ITEM, CMD_ACCESS,  9'd257, 1'b1, '{8'd0,   1'b1}},
            '{ROW_ITEM, CMD_ACCESS,  9'd511, 1'b1, '{8'd0,   1'b1}},
            '{ROW_ITEM, CMD_ACCESS,  9'd128, 1'b0, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd1,   1'b0, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_RESTART, 9'd511, 1'b0, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd256, 1'b1, '{8'd255, 1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd255, 1'b1, '{8'd255, 1'b0}},
            '{ROW_CFG,  CMD_ACCESS,  9'd0,   1'b0, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd1,   1'b1, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd2,   1'b1, '{8'd0,   1'b1}},
            '{ROW_ITEM, CMD_ACCESS,  9'd1,   1'b1, '{8'd0,   1'b0}},
            '{ROW_CFG,  CMD_ACCESS,  9'd511, 1'b0, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd256, 1'b1, '{8'd255, 1'b0}},
            '{ROW_CFG,  CMD_ACCESS,  9'd2,   1'b0, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd2,   1'b1, '{8'd1,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd1,   1'b1, '{8'd1,   1'b0}},
            '{ROW_ITEM, CMD_RESTART, 9'd0,   1'b0, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd2,   1'b1, '{8'd1,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd3,   1'b1, '{8'd0,   1'b1}},
            '{ROW_CFG,  CMD_ACCESS,  9'd257, 1'b0, '{8'd0,   1'b0}},
            '{ROW_ITEM, CMD_ACCESS,  9'd257, 1'b1, '{8'd0,   1'b1}},
            '{ROW_ITEM, CMD_ACCESS,  9'd170, 1'b0, '{8'd0,   1'b0}}
        };
        phase_cnt = '{9'd1, 9'd0, 9'd3, 9'd8, 9'd31, 9'd100,
                      9'd256, 9'd300, 9'd511, 9'd0, 9'd2, 9'd16};
        phase_cnt[9] = ITEM_W'($urandom_range(1, 511));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG)
                write_count(dir_tab[i].value);
            else
                send_item(dir_tab[i].cmd, dir_tab[i].value, dir_tab[i].typed,
                          dir_tab[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_count(phase_cnt[p]);
            ready_mode = t_ready_mode'(p % 3);
            no_gaps    = (p % 4 == 1);
            eff        = live_count;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r   = $urandom_range(0, 99);
                cmd = CMD_ACCESS;
                if (r < 3) begin
                    cmd = CMD_RESTART;
                    id  = ITEM_W'($urandom);
                end else if (r < 9) begin
                    id = ITEM_W'($urandom);
                end else if (r < 13) begin
                    id = $urandom_range(0, 1) ? '0 : ITEM_W'(eff + 1);
                end else if (r < 40) begin
                    // small working set keeps ranks low and repeats common
                    id = ITEM_W'($urandom_range(1, (eff < 4) ? eff : 4));
                end else begin
                    id = ITEM_W'($urandom_range(1, eff));
                end
                send_item(cmd, id, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && pending_ranks.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
